[rtl/imu_frame_parser_scaler_assert.svh]
// Assertion macros for the IMU frame parser and scaler.
`ifndef IMU_FRAME_PARSER_SCALER_ASSERT_SVH
`define IMU_FRAME_PARSER_SCALER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IMUFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define IMUFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IMUFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define IMUFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/imufps_pkg.sv]
// Shared types, constants and helpers for the IMU frame parser and scaler.
`default_nettype none

package imufps_pkg;

  localparam int BYTE_W      = 8;
  localparam int GAIN_W      = 16;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 3;
  localparam int RAW_W       = 16;
  localparam int SCALED_W    = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SCALE_SHIFT = 15;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_TYPE,
    PH_SKIP,
    PH_LOW,
    PH_HIGH,
    PH_TAIL
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC       = 3'd0,
    REG_ANGLE_GAIN = 3'd1,
    REG_QUAT_GAIN  = 3'd2,
    REG_ACCEL_GAIN = 3'd3,
    REG_GYRO_GAIN  = 3'd4
  } cfg_reg_t;

  localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUAT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IMU   = 2'd2;

  localparam logic [BYTE_W-1:0] TYPE_FIRST = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_LAST  = 8'h03;

  localparam logic [BYTE_W-1:0] SYNC_RESET       = 8'h55;
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET = 16'd46080;
  localparam logic [GAIN_W-1:0] QUAT_GAIN_RESET  = 16'd256;
  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RESET = 16'd5018;
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RESET  = 16'd23040;

  // accel words come first in the IMU frame, rate words after
  localparam logic [IDX_W-1:0] IMU_GYRO_FIRST = 3'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [RAW_W-1:0]  raw;
    logic [GAIN_W-1:0] gain;
    logic              last;
  } word_item_t;

  function automatic logic [IDX_W-1:0] words_in_kind(input logic [KIND_W-1:0] kind);
    logic [IDX_W-1:0] n;
    unique case (kind)
      KIND_ANGLE: n = 3'd3;
      KIND_QUAT:  n = 3'd4;
      KIND_IMU:   n = 3'd6;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/imufps_if.sv]
// Valid/ready channel interfaces: received bytes, word results, register writes.
`default_nettype none

interface imufps_byte_if;
  logic                           valid;
  logic                           ready;
  logic [imufps_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface imufps_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [imufps_pkg::KIND_W-1:0]         frame_kind;
  logic [imufps_pkg::IDX_W-1:0]          field_index;
  logic signed [imufps_pkg::RAW_W-1:0]   raw_value;
  logic signed [imufps_pkg::SCALED_W-1:0] scaled_value;
  logic                                  last_field;

  modport source (output valid, output frame_kind, output field_index, output raw_value,
                  output scaled_value, output last_field, input ready);
  modport sink (input valid, input frame_kind, input field_index, input raw_value,
                input scaled_value, input last_field, output ready);
endinterface

interface imufps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [imufps_pkg::CFG_IDX_W-1:0]  index;
  logic [imufps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/imufps_parser.sv]
// Frame parser: config registers, sync/type state machine, word assembly and gain select.
`default_nettype none

module imufps_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  imufps_byte_if.sink                  rx,
  imufps_cfg_if.sink                   cfg,
  input  wire logic                    down_ready,
  output      logic                    word_valid,
  output      imufps_pkg::word_item_t  word_item
);
  import imufps_pkg::*;

  logic [BYTE_W-1:0] sync_value;
  logic [GAIN_W-1:0] angle_gain;
  logic [GAIN_W-1:0] quat_gain;
  logic [GAIN_W-1:0] accel_gain;
  logic [GAIN_W-1:0] gyro_gain;

  phase_t            phase;
  phase_t            phase_next;
  logic [IDX_W-1:0]  byte_count;
  logic [KIND_W-1:0] frame_type;
  logic [BYTE_W-1:0] low_byte_hold;

  logic              advance;
  logic              take;
  logic [BYTE_W-1:0] b;
  logic              sync_hit;
  logic              type_ok;
  logic              word_last;
  logic [GAIN_W-1:0] gain_sel;

  assign cfg.ready = 1'b1;
  assign advance   = !word_valid || down_ready;
  assign rx.ready  = advance;
  assign take      = rx.valid && advance;
  assign b         = rx.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      angle_gain <= ANGLE_GAIN_RESET;
      quat_gain  <= QUAT_GAIN_RESET;
      accel_gain <= ACCEL_GAIN_RESET;
      gyro_gain  <= GYRO_GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SYNC:       sync_value <= cfg.data[BYTE_W-1:0];
        REG_ANGLE_GAIN: angle_gain <= cfg.data;
        REG_QUAT_GAIN:  quat_gain  <= cfg.data;
        REG_ACCEL_GAIN: accel_gain <= cfg.data;
        REG_GYRO_GAIN:  gyro_gain  <= cfg.data;
        default: ;
      endcase
    end
  end

  // decode of the current byte and frame position
  always_comb begin
    sync_hit  = (b == sync_value);
    type_ok   = (b >= TYPE_FIRST) && (b <= TYPE_LAST);
    word_last = ({1'b0, byte_count} + 4'd1) >= {1'b0, words_in_kind(frame_type)};
    priority if (frame_type == KIND_ANGLE) begin
      gain_sel = angle_gain;
    end else if (frame_type == KIND_QUAT) begin
      gain_sel = quat_gain;
    end else if (byte_count < IMU_GYRO_FIRST) begin
      gain_sel = accel_gain;
    end else begin
      gain_sel = gyro_gain;
    end
  end

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_HUNT1: phase_next = sync_hit ? PH_HUNT2 : PH_HUNT1;
        PH_HUNT2: phase_next = sync_hit ? PH_TYPE : PH_HUNT1;
        PH_TYPE:  phase_next = type_ok ? PH_SKIP : PH_HUNT1;
        PH_SKIP:  phase_next = PH_LOW;
        PH_LOW:   phase_next = PH_HIGH;
        PH_HIGH:  phase_next = word_last ? PH_TAIL : PH_LOW;
        PH_TAIL:  phase_next = PH_HUNT1;
        default:  phase_next = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      byte_count    <= '0;
      frame_type    <= '0;
      low_byte_hold <= '0;
    end else begin
      phase <= phase_next;
      if (take) begin
        if (phase == PH_TYPE && type_ok) begin
          frame_type <= KIND_W'(b - TYPE_FIRST);
          byte_count <= '0;
        end
        if (phase == PH_LOW) begin
          low_byte_hold <= b;
        end
        if (phase == PH_HIGH) begin
          byte_count <= word_last ? '0 : byte_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (advance) begin
      word_valid <= take && (phase == PH_HIGH);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_item.kind <= frame_type;
      word_item.idx  <= byte_count;
      word_item.raw  <= {b, low_byte_hold};
      word_item.gain <= gain_sel;
      word_item.last <= word_last;
    end
  end

endmodule

`default_nettype wire

[rtl/imufps_scaler.sv]
// Gain multiply and result register with output handshake.
`default_nettype none

module imufps_scaler (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    word_valid,
  input  wire imufps_pkg::word_item_t  word_item,
  output      logic                    up_ready,
  imufps_result_if.source              res
);
  import imufps_pkg::*;

  logic signed [RAW_W+GAIN_W:0] prod;
  logic signed [RAW_W+GAIN_W:0] prod_shr;

  // signed raw times unsigned gain, floor via arithmetic shift
  assign prod     = $signed(word_item.raw) * $signed({1'b0, word_item.gain});
  assign prod_shr = prod >>> SCALE_SHIFT;
  assign up_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (up_ready) begin
      res.valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      res.frame_kind   <= word_item.kind;
      res.field_index  <= word_item.idx;
      res.raw_value    <= $signed(word_item.raw);
      res.scaled_value <= prod_shr[SCALED_W-1:0];
      res.last_field   <= word_item.last;
    end
  end

endmodule

`default_nettype wire

[rtl/imu_frame_parser_scaler.sv]
// Top level of the IMU frame parser and scaler.
//
// rx carries one received serial byte per item; res carries one item per
// completed 16-bit word: frame kind, field index, raw word, scaled word and a
// last-field flag. cfg writes the sync byte value and the four gains; index
// is the register number, writes beyond the last register are dropped, and
// cfg is always ready.
// The edge that takes the high byte of a word loads it into the parser's word
// register; from there it passes through the single 16x17 multiply, which is
// combinational, into the result register. One byte is taken every cycle
// while rx.ready is high. When res stalls, the result and the word register
// each hold one item, then rx.ready drops until res is taken. Reset (rst,
// synchronous) returns the parser to hunting the first sync byte, loads the
// register defaults and empties both stages; there is no clearing pass.
`default_nettype none
`include "imu_frame_parser_scaler_assert.svh"

module imu_frame_parser_scaler (
  input  wire logic       clk,
  input  wire logic       rst,
  imufps_byte_if.sink     rx,
  imufps_cfg_if.sink      cfg,
  imufps_result_if.source res
);
  import imufps_pkg::*;

  logic       word_valid;
  word_item_t word_item;
  logic       scaler_ready;

  imufps_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .down_ready (scaler_ready),
    .word_valid (word_valid),
    .word_item  (word_item)
  );

  imufps_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_item  (word_item),
    .up_ready   (scaler_ready),
    .res        (res)
  );

  `IMUFPS_ASSERT_NEXT(a_word_holds, clk, rst, word_valid && !scaler_ready,
    word_valid && $stable(word_item), "word item lost while stalled")
  `IMUFPS_ASSERT_NEXT(a_word_moves, clk, rst, word_valid && scaler_ready,
    res.valid, "word item not moved to result")
  `IMUFPS_ASSERT_SAME(a_last_pos, clk, rst, res.valid && res.last_field,
    (res.frame_kind == KIND_ANGLE && res.field_index == 3'd2) ||
    (res.frame_kind == KIND_QUAT && res.field_index == 3'd3) ||
    (res.frame_kind == KIND_IMU && res.field_index == 3'd5), "last flag misplaced")

endmodule

`default_nettype wire
